FILE: rtl/bpa_pkg.sv
package bpa_pkg;

  // Ring geometry. The depth must be a power of two so that the ring
  // pointer wraps by itself.
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [7:0] PAGE_POWER_ONLY  = 8'h10;
  localparam logic [7:0] PAGE_CALIBRATION = 8'h01;

  localparam logic [1:0] REQ_PAGE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_CLOSED  = 2'd2;

  localparam logic [1:0] KIND_POWER   = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_CLOSED  = 2'd2;

  // Instant power that means "none seen yet".
  localparam logic [15:0] INST_NONE = 16'hFFFF;

  localparam logic [6:0] WINDOW_RESET = 7'd1;

  // Quotient bits of the 24-bit by 8-bit division.
  localparam int DIV_STEPS = 24;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RD_NEW,
    ST_RD_OLD,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic rd_oldest;
    logic take_newest;
    logic check;
    logic div_step;
    logic out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic has_msg;
    logic fallback;
  } bpa_sts_t;

endpackage

FILE: rtl/bpa_ifs.sv
interface bpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  page_id;
  logic [7:0]  page_event_count;
  logic [15:0] page_accum_power;
  logic signed [15:0] page_instant_power;

  modport source (output valid, req_type, page_id, page_event_count,
                  page_accum_power, page_instant_power, input ready);
  modport sink   (input valid, req_type, page_id, page_event_count,
                  page_accum_power, page_instant_power, output ready);
endinterface

interface bpa_out_if;
  logic        valid;
  logic        ready;
  logic        msg_valid;
  logic [1:0]  msg_kind;
  logic signed [15:0] msg_watts;
  logic signed [24:0] avg_power;

  modport source (output valid, msg_valid, msg_kind, msg_watts, avg_power,
                  input ready);
  modport sink   (input valid, msg_valid, msg_kind, msg_watts, avg_power,
                  output ready);
endinterface

interface bpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_seconds;

  modport source (output valid, window_seconds, input ready);
  modport sink   (input valid, window_seconds, output ready);
endinterface

FILE: rtl/bpa_ctrl.sv
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [DIV_CW-1:0]  cnt;
  logic [DIV_CW-1:0]  cnt_next;
  logic               out_full;
  logic               out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.has_msg ? ST_RD_NEW : ST_FINISH;
      end
      ST_RD_NEW: begin
        state_next = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        cmd.rd_oldest   = 1'b1;
        cmd.take_newest = 1'b1;
        state_next      = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        cnt_next   = '0;
        state_next = sts.fallback ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  assign out_valid = out_full;

endmodule

FILE: rtl/bpa_dpath.sv
module bpa_dpath (
  input  logic               clk,
  input  logic               rst,
  input  bpa_pkg::bpa_cmd_t  cmd,
  output bpa_pkg::bpa_sts_t  sts,
  input  logic [1:0]         req_type,
  input  logic [7:0]         page_id,
  input  logic [7:0]         page_event_count,
  input  logic [15:0]        page_accum_power,
  input  logic signed [15:0] page_instant_power,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_window,
  output logic               msg_valid,
  output logic [1:0]         msg_kind,
  output logic signed [15:0] msg_watts,
  output logic signed [24:0] avg_power
);
  import bpa_pkg::*;

  // Latched request.
  logic [1:0]  req_q;
  logic [7:0]  page_q;
  logic [7:0]  count_q;
  logic [15:0] accum_q;
  logic [15:0] inst_q;

  // Block state.
  logic [6:0]         window;
  logic [RING_AW-1:0] head;
  logic [15:0]        last_inst;
  logic [23:0]        ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;

  // Read port.
  logic [RING_AW-1:0] newest;
  logic [RING_AW-1:0] oldest;
  logic [RING_AW-1:0] rd_addr;
  logic [23:0]        rd_q;
  logic               rd_vld_q;
  logic [23:0]        rd_data;
  logic [23:0]        newest_q;

  // Average computation.
  logic [7:0]  dcount;
  logic [15:0] daccum;
  logic        fallback_q;
  logic [23:0] quo;
  logic [7:0]  rem;
  logic [7:0]  div_d;
  logic [8:0]  rem_sh;
  logic [8:0]  rem_sub;

  logic is_power;
  logic is_calib;
  logic has_msg;

  assign is_power = (req_q == REQ_PAGE) && (page_q == PAGE_POWER_ONLY);
  assign is_calib = (req_q == REQ_PAGE) && (page_q == PAGE_CALIBRATION);
  assign has_msg  = is_power || is_calib || (req_q == REQ_TIMEOUT) ||
                    (req_q == REQ_CLOSED);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= req_type;
      page_q  <= page_id;
      count_q <= page_event_count;
      accum_q <= page_accum_power;
      inst_q  <= page_instant_power;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RESET;
      head      <= '0;
      last_inst <= INST_NONE;
      ring_vld  <= '0;
    end else begin
      if (cfg_we) begin
        window <= cfg_window;
      end
      if (cmd.update && is_power) begin
        head           <= head + 1'b1;
        last_inst      <= inst_q;
        ring_vld[head] <= 1'b1;
      end else if (cmd.update && (req_q == REQ_TIMEOUT)) begin
        last_inst <= INST_NONE;
      end
    end
  end

  // The look-back is twice the window, taken modulo the ring depth.
  assign newest  = head - 1'b1;
  assign oldest  = newest - RING_AW'({window, 1'b0});
  assign rd_addr = cmd.rd_oldest ? oldest : newest;

  always_ff @(posedge clk) begin
    if (cmd.update && is_power) begin
      ring_mem[head] <= {count_q, accum_q};
    end
    rd_q     <= ring_mem[rd_addr];
    rd_vld_q <= ring_vld[rd_addr];
  end

  // Entries never written read as zero.
  assign rd_data = rd_vld_q ? rd_q : 24'h000000;

  always_ff @(posedge clk) begin
    if (cmd.take_newest) begin
      newest_q <= rd_data;
    end
  end

  assign dcount = newest_q[23:16] - rd_data[23:16];
  assign daccum = newest_q[15:0] - rd_data[15:0];

  // Restoring division, one quotient bit per step.
  assign rem_sh  = {rem, quo[23]};
  assign rem_sub = rem_sh - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fallback_q <= (dcount == 8'h00) || (rd_data[15:0] == 16'h0000);
      quo        <= {daccum, 8'h00};
      rem        <= 8'h00;
      div_d      <= dcount;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, div_d}) begin
        rem <= rem_sub[7:0];
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= rem_sh[7:0];
        quo <= {quo[22:0], 1'b0};
      end
    end
  end

  assign sts.has_msg  = has_msg;
  assign sts.fallback = (dcount == 8'h00) || (rd_data[15:0] == 16'h0000);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      msg_valid <= has_msg;
      msg_kind  <= has_msg ? req_q : KIND_POWER;
      msg_watts <= is_power ? inst_q : 16'sh0000;
      if (!has_msg) begin
        avg_power <= '0;
      end else if (fallback_q) begin
        avg_power <= {last_inst[15], last_inst, 8'h00};
      end else begin
        avg_power <= {1'b0, quo};
      end
    end
  end

endmodule

FILE: rtl/bike_power_page_averager.sv
// A request that raises no message goes from the update state straight to the
// result register; otherwise both ring reads and the fallback check come first,
// and the 24-step divider runs unless the average falls back to instant power.
// One request is in flight at a time; the next is taken once the previous result
// is loaded, waiting on the divider, the single ring read port and the sink.
// Reset (rst, synchronous, active high) empties the ring, sets the window to 1 s.
module bike_power_page_averager (
  input logic       clk,
  input logic       rst,
  bpa_in_if.sink    req,
  bpa_out_if.source msg,
  bpa_cfg_if.sink   cfg
);
  import bpa_pkg::*;

  // The controller sequences each request through the update and, for a message,
  // two ring reads, the fallback check and, if needed, the divider; the datapath
  // holds the ring, the latched request, the divider and the output register.
  bpa_cmd_t cmd;
  bpa_sts_t sts;

  // The window register may be written at any time the block is idle, so
  // the configuration channel is always ready.
  assign cfg.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (msg.valid),
    .out_ready (msg.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The result register sits between the two sides: a finished result may
  // wait for the sink while the next request is already accepted.
  bpa_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_type           (req.req_type),
    .page_id            (req.page_id),
    .page_event_count   (req.page_event_count),
    .page_accum_power   (req.page_accum_power),
    .page_instant_power (req.page_instant_power),
    .cfg_we             (cfg.valid),
    .cfg_window         (cfg.window_seconds),
    .msg_valid          (msg.msg_valid),
    .msg_kind           (msg.msg_kind),
    .msg_watts          (msg.msg_watts),
    .avg_power          (msg.avg_power)
  );

endmodule

FILE: rtl/bpa_checker.sv
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        msg_valid,
  input logic [1:0]  msg_kind,
  input logic [15:0] msg_watts,
  input logic [24:0] avg_power
);

  // A held result must stay until the sink takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A result without a message carries all-zero fields.
  a_no_msg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !msg_valid |-> msg_kind == 2'd0 && msg_watts == 16'h0000 &&
    avg_power == 25'h0000000)
    else $error("non-message result carries data");

  // Timeouts and closes report no instant watts.
  a_status_no_watts: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_kind != 2'd0 |-> msg_watts == 16'h0000)
    else $error("status message carries watts");

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bike_power_page_averager bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (msg.valid),
  .out_ready (msg.ready),
  .msg_valid (msg.msg_valid),
  .msg_kind  (msg.msg_kind),
  .msg_watts (msg.msg_watts),
  .avg_power (msg.avg_power)
);
